>>> design/emt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emt_pkg
// shared types and constants of the multi-turn encoder tracker
// ----------------------------------------------------------------------------
package emt_pkg;

    localparam int POS_W           = 13;
    localparam int COUNTS_PER_TURN = 8192;
    localparam int RATE_W          = 14;
    localparam int TURN_W          = 16;
    localparam int TOTAL_W         = 30;
    localparam int SEEN_W          = 8;
    localparam int THR_W           = 13;
    localparam int CALIB_W         = 8;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_FIELD_W = TOTAL_W + RATE_W + RATE_W + TURN_W;
    localparam int OUT_TDATA_W = 80;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WRAP_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CALIB_READINGS = 1'b1;

    localparam logic [THR_W-1:0]   WRAP_THRESHOLD_RST = 13'd4096;
    localparam logic [CALIB_W-1:0] CALIB_READINGS_RST = 8'd51;

    localparam logic [SEEN_W-1:0]        SEEN_MAX = 8'hFF;
    localparam logic signed [TURN_W-1:0] TURN_MAX = 16'sh7FFF;
    localparam logic signed [TURN_W-1:0] TURN_MIN = 16'sh8000;

    // one turn, at the width of a wrap-corrected step
    localparam logic signed [RATE_W:0] TURN_SPAN = (RATE_W+1)'(COUNTS_PER_TURN);

    // what the tracking stage hands to the output stage
    typedef struct packed {
        logic                     calib;
        logic signed [TURN_W-1:0] turns;
        logic signed [RATE_W-1:0] pos_delta;
        logic signed [RATE_W-1:0] rate;
        logic                     sum_neg;
    } emt_stage_t;

endpackage

>>> design/emt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emt_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module emt_ram #(
    parameter int WIDTH  = 14,
    parameter int DEPTH  = 25,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/emt_track.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emt_track
// offset capture, wrap detection, turn counter and rate ring read-modify-write
// ----------------------------------------------------------------------------
module emt_track import emt_pkg::*; #(
    parameter int AVG_LEN = 25,
    localparam int SUM_W  = RATE_W + $clog2(AVG_LEN)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  accept,
    input  logic                  advance,
    input  logic [POS_W-1:0]      position,
    output logic                  stage_valid,
    output emt_stage_t            stage,
    output logic [SUM_W-1:0]      sum_mag
);

    localparam int IDX_W = (AVG_LEN > 1) ? $clog2(AVG_LEN) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(AVG_LEN - 1);

    logic [THR_W-1:0]         wrap_threshold_reg;
    logic [CALIB_W-1:0]       calib_readings_reg;
    logic [SEEN_W-1:0]        readings_seen_reg;
    logic [POS_W-1:0]         zero_offset_reg;
    logic [POS_W-1:0]         previous_position_reg;
    logic signed [TURN_W-1:0] turns_reg;
    logic [IDX_W-1:0]         ring_index_reg;
    logic signed [SUM_W-1:0]  ring_sum_reg;
    logic [AVG_LEN-1:0]       ring_valid_reg;
    logic                     fwd_hit_reg;
    logic signed [RATE_W-1:0] fwd_data_reg;
    logic                     stage_valid_reg;
    emt_stage_t               stage_reg;
    logic [SUM_W-1:0]         sum_mag_reg;

    logic                     is_calib;
    logic                     step;
    logic signed [RATE_W-1:0] diff;
    logic signed [RATE_W:0]   diff_x;
    logic signed [RATE_W:0]   thr_x;
    logic                     wrap_back;
    logic                     wrap_fwd;
    logic signed [RATE_W:0]   rate_x;
    logic signed [RATE_W-1:0] rate;
    logic signed [TURN_W-1:0] turns_next;
    logic signed [RATE_W-1:0] pos_delta;
    logic [RATE_W-1:0]        rd_data;
    logic signed [RATE_W-1:0] old_rate;
    logic signed [SUM_W-1:0]  ring_sum_next;
    logic [SUM_W-1:0]         sum_abs;
    logic [IDX_W-1:0]         ring_index_next;
    logic [IDX_W-1:0]         rd_addr;

    // wrap detection and turn update
    always_comb
    begin
        is_calib  = readings_seen_reg < calib_readings_reg;
        step      = accept && !is_calib;
        diff      = $signed({1'b0, position}) - $signed({1'b0, previous_position_reg});
        diff_x    = (RATE_W+1)'(diff);
        thr_x     = $signed({2'b00, wrap_threshold_reg});
        wrap_back = diff_x > thr_x;
        wrap_fwd  = diff_x < -thr_x;
        if (wrap_back)
        begin
            rate_x = diff_x - TURN_SPAN;
        end
        else if (wrap_fwd)
        begin
            rate_x = diff_x + TURN_SPAN;
        end
        else
        begin
            rate_x = diff_x;
        end
        rate = rate_x[RATE_W-1:0];

        turns_next = turns_reg;
        if (wrap_back && (turns_reg != TURN_MIN))
        begin
            turns_next = turns_reg - 16'sd1;
        end
        else if (wrap_fwd && (turns_reg != TURN_MAX))
        begin
            turns_next = turns_reg + 16'sd1;
        end

        pos_delta = $signed({1'b0, position}) - $signed({1'b0, zero_offset_reg});
    end

    // ring slot read-modify-write, unwritten slots read as zero
    always_comb
    begin
        if (!ring_valid_reg[ring_index_reg])
        begin
            old_rate = '0;
        end
        else if (fwd_hit_reg)
        begin
            old_rate = fwd_data_reg;
        end
        else
        begin
            old_rate = $signed(rd_data);
        end
        ring_sum_next = ring_sum_reg - SUM_W'(old_rate) + SUM_W'(rate);
        sum_abs       = ring_sum_next[SUM_W-1] ? SUM_W'(-ring_sum_next)
                                               : SUM_W'(ring_sum_next);
        ring_index_next = (ring_index_reg == IDX_LAST) ? '0 : ring_index_reg + 1'b1;
        // prefetch the slot that the next reading will replace
        rd_addr = step ? ring_index_next : ring_index_reg;
    end

    emt_ram #(
        .WIDTH (RATE_W),
        .DEPTH (AVG_LEN)
    ) u_ring (
        .clk     (clk),
        .we      (step),
        .wr_addr (ring_index_reg),
        .wr_data (rate),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_threshold_reg    <= WRAP_THRESHOLD_RST;
            calib_readings_reg    <= CALIB_READINGS_RST;
            readings_seen_reg     <= '0;
            zero_offset_reg       <= '0;
            previous_position_reg <= '0;
            turns_reg             <= '0;
            ring_index_reg        <= '0;
            ring_sum_reg          <= '0;
            ring_valid_reg        <= '0;
            fwd_hit_reg           <= 1'b0;
            stage_valid_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_WRAP_THRESHOLD: wrap_threshold_reg <= cfg_data[THR_W-1:0];
                    REG_CALIB_READINGS: calib_readings_reg <= cfg_data[CALIB_W-1:0];
                    default: ;
                endcase
            end

            if (accept)
            begin
                previous_position_reg <= position;
                if (is_calib)
                begin
                    readings_seen_reg <= readings_seen_reg + 1'b1;
                    zero_offset_reg   <= position;
                end
                else
                begin
                    if (readings_seen_reg != SEEN_MAX)
                    begin
                        readings_seen_reg <= readings_seen_reg + 1'b1;
                    end
                    turns_reg                      <= turns_next;
                    ring_sum_reg                   <= ring_sum_next;
                    ring_valid_reg[ring_index_reg] <= 1'b1;
                    ring_index_reg                 <= ring_index_next;
                end
            end

            // read and write of one slot at the same edge: ram returns stale data
            fwd_hit_reg <= step && (rd_addr == ring_index_reg);

            if (accept)
            begin
                stage_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                stage_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= rate;
        if (accept)
        begin
            stage_reg.calib     <= is_calib;
            stage_reg.turns     <= is_calib ? turns_reg : turns_next;
            stage_reg.pos_delta <= pos_delta;
            stage_reg.rate      <= rate;
            stage_reg.sum_neg   <= ring_sum_next[SUM_W-1];
            sum_mag_reg         <= sum_abs;
        end
    end

    assign stage_valid = stage_valid_reg;
    assign stage       = stage_reg;
    assign sum_mag     = sum_mag_reg;

endmodule

>>> design/emt_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emt_out
// averaging divide, total count and the result register
// ----------------------------------------------------------------------------
module emt_out import emt_pkg::*; #(
    parameter int AVG_LEN = 25,
    localparam int SUM_W  = RATE_W + $clog2(AVG_LEN)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      advance,
    input  emt_stage_t                stage,
    input  logic [SUM_W-1:0]          sum_mag,
    input  logic                      out_ready,
    output logic                      out_valid,
    output logic                      calibrating,
    output logic signed [TOTAL_W-1:0] total_count,
    output logic signed [RATE_W-1:0]  raw_rate,
    output logic signed [RATE_W-1:0]  filtered_rate,
    output logic signed [TURN_W-1:0]  turn_count
);

    // divide by AVG_LEN as multiply by a rounded-up reciprocal
    localparam int    SHIFT  = SUM_W + $clog2(AVG_LEN);
    localparam int    MUL_W  = SHIFT + 1;
    localparam int    PROD_W = SUM_W + MUL_W;
    localparam longint RECIP = ((64'd1 << SHIFT) + AVG_LEN - 1) / AVG_LEN;
    localparam logic [MUL_W-1:0] RECIP_V = MUL_W'(RECIP);

    logic                      out_valid_reg;
    logic                      calibrating_reg;
    logic signed [TOTAL_W-1:0] total_count_reg;
    logic signed [RATE_W-1:0]  raw_rate_reg;
    logic signed [RATE_W-1:0]  filtered_rate_reg;
    logic signed [TURN_W-1:0]  turn_count_reg;

    logic [PROD_W-1:0]         product;
    logic [RATE_W-1:0]         quot;
    logic signed [RATE_W-1:0]  filt;
    logic signed [TOTAL_W-1:0] total;

    always_comb
    begin
        product = PROD_W'(sum_mag) * PROD_W'(RECIP_V);
        quot    = product[SHIFT +: RATE_W];
        // truncation toward zero: divide the magnitude, then restore the sign
        filt    = stage.sum_neg ? -$signed(quot) : $signed(quot);
        total   = (TOTAL_W'(stage.turns) <<< POS_W) + TOTAL_W'(stage.pos_delta);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            calibrating_reg   <= stage.calib;
            turn_count_reg    <= stage.turns;
            total_count_reg   <= stage.calib ? '0 : total;
            raw_rate_reg      <= stage.calib ? '0 : stage.rate;
            filtered_rate_reg <= stage.calib ? '0 : filt;
        end
    end

    assign out_valid     = out_valid_reg;
    assign calibrating   = calibrating_reg;
    assign total_count   = total_count_reg;
    assign raw_rate      = raw_rate_reg;
    assign filtered_rate = filtered_rate_reg;
    assign turn_count    = turn_count_reg;

endmodule

>>> design/encoder_multiturn_tracker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_multiturn_tracker_core
// multi-turn unwrap of a 13-bit encoder with a moving-average rate
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one encoder reading per beat, m_axis one result per beat
//   cfg_we/cfg_index/cfg_data write wrap_threshold (0) and calib_readings (1);
//   write only while no beat is in flight
//   the first calib_readings readings only capture the zero offset and come
//   back with tuser set and zero count and rates
//   an accepted beat is registered in the middle stage, then in the result
//   register that drives m_axis, and leaves when m_axis_tready is high
//   throughput: one beat per cycle while m_axis is not held; turns, offset
//   and ring sum update in a single step, fed by a ring slot that is
//   prefetched from the rate ram as the previous reading is taken
//   the rate ring lives in a 25 x 14 ram; a valid bit per slot, cleared at
//   reset, makes unwritten slots read as zero, so there is no clearing pass
//   reset: config goes to 4096 / 51, all tracking state to zero, no beats out
//   stall: a held m_axis keeps its beat, the middle stage fills, then
//   s_axis_tready drops; no beat is lost or repeated
// ----------------------------------------------------------------------------
module encoder_multiturn_tracker_core import emt_pkg::*; #(
    parameter int AVG_LEN = 25,
    localparam int SUM_W  = RATE_W + $clog2(AVG_LEN)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [12:0] encoder_position, [15:13] zero
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [29:0] total_count, [43:30] raw_rate,
                                                   // [57:44] filtered_rate,
                                                   // [73:58] turn_count, [79:74] zero
    output logic                   m_axis_tuser    // [0] calibrating
);

    logic                      accept;
    logic                      advance;
    logic                      stage_valid;
    emt_stage_t                stage;
    logic [SUM_W-1:0]          sum_mag;
    logic                      calibrating;
    logic signed [TOTAL_W-1:0] total_count;
    logic signed [RATE_W-1:0]  raw_rate;
    logic signed [RATE_W-1:0]  filtered_rate;
    logic signed [TURN_W-1:0]  turn_count;

    // middle stage moves on when the result register is free or being drained
    assign advance       = stage_valid && (!m_axis_tvalid || m_axis_tready);
    assign s_axis_tready = !stage_valid || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;

    emt_track #(
        .AVG_LEN (AVG_LEN)
    ) u_track (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .accept      (accept),
        .advance     (advance),
        .position    (s_axis_tdata[POS_W-1:0]),
        .stage_valid (stage_valid),
        .stage       (stage),
        .sum_mag     (sum_mag)
    );

    emt_out #(
        .AVG_LEN (AVG_LEN)
    ) u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .stage         (stage),
        .sum_mag       (sum_mag),
        .out_ready     (m_axis_tready),
        .out_valid     (m_axis_tvalid),
        .calibrating   (calibrating),
        .total_count   (total_count),
        .raw_rate      (raw_rate),
        .filtered_rate (filtered_rate),
        .turn_count    (turn_count)
    );

    assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, turn_count, filtered_rate, raw_rate, total_count};
    assign m_axis_tuser = calibrating;

    // an accepted beat always lands in the middle stage
    a_accept_fills : assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> stage_valid)
        else $error("accepted beat did not reach the middle stage");

    // a blocked middle stage keeps its beat
    a_stage_holds : assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid && !advance |=> stage_valid && $stable(stage))
        else $error("middle stage lost a beat while blocked");

    // an offset-capture result carries no count and no rate
    a_calib_zero : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |->
            (total_count == '0) && (raw_rate == '0) && (filtered_rate == '0))
        else $error("offset-capture result with nonzero count or rate");

endmodule

>>> verif/encoder_multiturn_tracker_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_multiturn_tracker_core_tb
// self-checking bench for the multi-turn encoder tracker: a directed table
// walks reset values, register extremes, wrap edges and offset recapture,
// then random motion profiles run under several register settings with
// random idling on both streams; every result beat is compared field by
// field against a cycle-free tracking model kept in the bench
// ----------------------------------------------------------------------------
module encoder_multiturn_tracker_core_tb import emt_pkg::*; ();

    localparam int AVG_LEN      = 25;
    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 5;
    localparam int DRAIN_CYCLES = 4;
    localparam int MAX_GAP      = 14;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_ITEMS  = 100;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DIRECTED_ROWS = 29;

    // one result beat, split into its fields
    typedef struct packed {
        logic                      calibrating;
        logic signed [TOTAL_W-1:0] total_count;
        logic signed [RATE_W-1:0]  raw_rate;
        logic signed [RATE_W-1:0]  filtered_rate;
        logic signed [TURN_W-1:0]  turn_count;
    } track_t;

    typedef enum logic {ROW_READ, ROW_WRITE} row_kind_t;

    // one row of the directed table: a reading or a register write
    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  reg_sel;
        logic [CFG_DATA_W-1:0] value;
        logic                  typed;
        track_t                want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic m_axis_tuser;

    // tracking model state and its copy of the registers
    int thr_setting = WRAP_THRESHOLD_RST;
    int calib_setting = CALIB_READINGS_RST;
    int readings_taken = 0;
    logic [POS_W-1:0] offset_pos = '0;
    logic [POS_W-1:0] last_pos = '0;
    int turn_cnt = 0;
    int rate_hist [AVG_LEN];
    int hist_slot = 0;
    int hist_sum = 0;

    track_t expected_tracks [$];
    int mismatch_count = 0;
    int unsigned cycle_count = 0;
    bit send_idle = 1'b1;
    bit recv_stall = 1'b1;
    stim_row_t directed_rows [DIRECTED_ROWS];

    encoder_multiturn_tracker_core #(.AVG_LEN(AVG_LEN)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),    // [12:0] encoder_position, [15:13] zero
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),    // [29:0] total_count, [43:30] raw_rate,
                                          // [57:44] filtered_rate, [73:58] turn_count
        .m_axis_tuser  (m_axis_tuser)     // [0] calibrating
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("encoder_multiturn_tracker_core test failed");
            $finish;
        end
    end

    // unwrap one reading and return the result it should produce
    function automatic track_t track_reading(input logic [POS_W-1:0] pos);
        track_t r;
        int now_pos;
        int step;
        int rate;
        int total;
        int filt;
        r = '0;
        now_pos = pos;
        // offset capture only, the rate ring is left alone
        if (readings_taken < calib_setting)
        begin
            readings_taken++;
            offset_pos = pos;
            last_pos = pos;
            r.calibrating = 1'b1;
            r.turn_count = turn_cnt[TURN_W-1:0];
            return r;
        end
        if (readings_taken < SEEN_MAX)
            readings_taken++;
        step = now_pos - int'(last_pos);
        if (step > thr_setting)
        begin
            // backward wrap through zero
            if (turn_cnt > TURN_MIN)
                turn_cnt--;
            rate = step - COUNTS_PER_TURN;
        end
        else if (step < -thr_setting)
        begin
            if (turn_cnt < TURN_MAX)
                turn_cnt++;
            rate = step + COUNTS_PER_TURN;
        end
        else
            rate = step;
        last_pos = pos;
        total = turn_cnt * COUNTS_PER_TURN + now_pos - int'(offset_pos);
        hist_sum = hist_sum - rate_hist[hist_slot] + rate;
        rate_hist[hist_slot] = rate;
        hist_slot = (hist_slot + 1) % AVG_LEN;
        filt = hist_sum / AVG_LEN;
        r.total_count = total[TOTAL_W-1:0];
        r.raw_rate = rate[RATE_W-1:0];
        r.filtered_rate = filt[RATE_W-1:0];
        r.turn_count = turn_cnt[TURN_W-1:0];
        return r;
    endfunction

    function automatic stim_row_t read_row(input logic [POS_W-1:0] pos);
        stim_row_t r;
        r = '0;
        r.kind = ROW_READ;
        r.value = CFG_DATA_W'(pos);
        return r;
    endfunction

    // reading taken while the offset is still being captured, turns at zero
    function automatic stim_row_t calib_row(input logic [POS_W-1:0] pos);
        stim_row_t r;
        r = read_row(pos);
        r.typed = 1'b1;
        r.want.calibrating = 1'b1;
        return r;
    endfunction

    function automatic stim_row_t write_row(input logic [CFG_IDX_W-1:0] sel,
                                            input logic [CFG_DATA_W-1:0] val);
        stim_row_t r;
        r = '0;
        r.kind = ROW_WRITE;
        r.reg_sel = sel;
        r.value = val;
        return r;
    endfunction

    // one reading beat; valid stays high across back-to-back beats
    task automatic send_reading(input logic [POS_W-1:0] pos,
                                input logic typed = 1'b0,
                                input track_t want = '0);
        int gap;
        track_t predicted;
        gap = send_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= IN_TDATA_W'(pos);
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted = track_reading(pos);
        expected_tracks.push_back(typed ? want : predicted);
    endtask

    // quiet the input and wait for every outstanding result
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_tracks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] sel,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= sel;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (sel == REG_WRAP_THRESHOLD)
            thr_setting = val[THR_W-1:0];
        else if (sel == REG_CALIB_READINGS)
            calib_setting = val[CALIB_W-1:0];
        @(posedge clk);
    endtask

    task automatic field_check(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        end
    endtask

    // result side: random stalls on tready, compare each beat
    initial
    begin
        int gap;
        track_t got;
        track_t want;
        @(posedge clk);
        forever
        begin
            gap = recv_stall ? $urandom_range(0, MAX_GAP) : 0;
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            got.calibrating = m_axis_tuser;
            got.total_count = m_axis_tdata[TOTAL_W-1:0];
            got.raw_rate = m_axis_tdata[TOTAL_W +: RATE_W];
            got.filtered_rate = m_axis_tdata[TOTAL_W+RATE_W +: RATE_W];
            got.turn_count = m_axis_tdata[TOTAL_W+2*RATE_W +: TURN_W];
            if (expected_tracks.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: result beat with nothing expected, expected none got %h",
                         $time, got);
            end
            else
            begin
                want = expected_tracks.pop_front();
                field_check("calibrating", want.calibrating, got.calibrating);
                field_check("total_count", want.total_count, got.total_count);
                field_check("raw_rate", want.raw_rate, got.raw_rate);
                field_check("filtered_rate", want.filtered_rate, got.filtered_rate);
                field_check("turn_count", want.turn_count, got.turn_count);
            end
        end
    end

    initial
    begin
        int thr_val;
        int calib_val;
        int vel;
        logic [POS_W-1:0] motor_pos;

        // reset values first, then the wrap edges at each threshold extreme, then offset recapture
        directed_rows = '{
            calib_row(13'd0), calib_row(13'd8191), calib_row(13'd4096),
            calib_row(13'd1), calib_row(13'h1555), calib_row(13'h0AAA),
            // no calibration: steps go on from the last captured reading
            write_row(REG_CALIB_READINGS, 13'd0),
            read_row(13'd8191), read_row(13'd0), read_row(13'd4096),
            read_row(13'd0), read_row(13'd4097),
            // zero threshold: every nonzero step is a wrap
            write_row(REG_WRAP_THRESHOLD, 13'd0),
            read_row(13'd4097), read_row(13'd4098), read_row(13'd4097),
            write_row(REG_WRAP_THRESHOLD, 13'd8191),
            read_row(13'd0), read_row(13'd8191), read_row(13'd0),
            write_row(REG_WRAP_THRESHOLD, 13'd1),
            read_row(13'd1), read_row(13'd3),
            // raising the count again recaptures the offset, turns are kept
            write_row(REG_CALIB_READINGS, 13'd255),
            read_row(13'd8191), read_row(13'd100),
            write_row(REG_CALIB_READINGS, 13'd22),
            read_row(13'd200), read_row(13'd300)
        };

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_WRITE)
            begin
                drain_results();
                write_reg(directed_rows[i].reg_sel, directed_rows[i].value);
            end
            else
                send_reading(directed_rows[i].value[POS_W-1:0], directed_rows[i].typed,
                             directed_rows[i].want);
        end

        // random motion: mostly a rotating shaft, some jumps anywhere
        motor_pos = last_pos;
        vel = 0;
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            drain_results();
            case ($urandom_range(0, 5))
                0: thr_val = 0;
                1: thr_val = 1;
                2: thr_val = 8191;
                default: thr_val = $urandom_range(3000, 6500);
            endcase
            case ($urandom_range(0, 4))
                0: calib_val = 255;
                1: calib_val = $urandom_range(0, 255);
                default: calib_val = $urandom_range(0, 6);
            endcase
            write_reg(REG_WRAP_THRESHOLD, CFG_DATA_W'(thr_val));
            // bits above the 8-bit count must be dropped
            write_reg(REG_CALIB_READINGS, {5'($urandom), 8'(calib_val)});
            send_idle = ($urandom_range(0, 3) != 0);
            recv_stall = ($urandom_range(0, 3) != 0);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if ($urandom_range(0, 9) == 0)
                    motor_pos = POS_W'($urandom);
                else
                begin
                    if ($urandom_range(0, 15) == 0)
                        vel = $urandom_range(0, 6000) - 3000;
                    motor_pos = POS_W'(int'(motor_pos) + vel);
                end
                send_reading(motor_pos);
            end
        end

        drain_results();
        if (mismatch_count == 0)
            $display("encoder_multiturn_tracker_core test passed");
        else
            $display("encoder_multiturn_tracker_core test failed");
        $finish;
    end

endmodule
